[rtl/pbaf_pkg.sv]
// Shared types and constants for the prebuffered audio byte FIFO.
package pbaf_pkg;

  // Field widths of the item and result streams
  localparam int unsigned MODE_W = 2;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned FILL_W = 13;
  localparam int unsigned THR_W  = 17;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned PROD_W = 30;

  localparam int unsigned IN_W  = 72;
  localparam int unsigned OUT_W = 248;

  // Register reset values and limits
  localparam logic [FILL_W-1:0] CAP_RESET = 13'd4096;
  localparam logic [THR_W-1:0]  THR_RESET = 17'd32768;
  localparam logic [THR_W-1:0]  THR_FULL  = 17'd65536;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_CAPACITY  = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_EMPTY  = 2'd0,
    PH_PREBUF = 2'd1,
    PH_STREAM = 2'd2,
    PH_UNDER  = 2'd3
  } phase_e;

endpackage

[rtl/prebuffered_audio_fifo.sv]
// Prebuffered audio byte FIFO: banked byte store, phase machine and statistics.
//
// Usage
//   Items enter on the s_axis channel: a mode (write, read, clear), a length of
//   up to LANES bytes and up to eight bytes of write data. Every item yields
//   exactly one result on m_axis: bytes moved, bytes read, phase, fill level and
//   the four wrapping statistics counters as they stand after the access.
//   Reads return nothing until the fill reaches the start threshold
//   (fill * 65536 >= threshold * capacity), checked after each storing write.
//   The APB port holds capacity_bytes (address 0) and start_threshold_q16
//   (address 4); writing the capacity empties the store and zeroes counters.
// Timing
//   One item per cycle while m_axis_tready_i stays high; the result is valid
//   the cycle after acceptance, set by the registered read port of each byte bank.
// Reset
//   Store empty, phase empty, counters zero, capacity 4096, threshold 32768.
//   The store contents themselves are not cleared; only written bytes are read.
// Stall
//   A waiting result is held in the output register; a new item is taken in the
//   same cycle the result leaves, otherwise s_axis_tready_o stays low.
module prebuffered_audio_fifo
  import pbaf_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Item stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [1:0] mode, [5:2] request_length, [69:6] write_bytes, [71:70] zero
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // Result stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [3:0] moved_count, [67:4] read_bytes, [69:68] buffer_state,
  // [82:70] fill_bytes, [114:83] overrun_total, [146:115] underrun_total,
  // [194:147] written_total, [242:195] read_total, [247:243] zero
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // Configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Store geometry: pointers run over a power-of-two ring, banked by low bits
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned BW   = (LANES > 1) ? $clog2(LANES) : 0;
  localparam int unsigned NB   = 1 << BW;
  localparam int unsigned BIW  = (BW > 0) ? BW : 1;
  localparam int unsigned RW   = AW - BW;
  localparam int unsigned ROWS = 1 << RW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FILL_W-1:0] cap_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_wr;
  logic              cfg_cap_wr;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign cfg_cap_wr = cfg_wr & (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CAPACITY) begin
        cap_q <= pwdata[FILL_W-1:0];
      end else begin
        thr_q <= pwdata[THR_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(32-FILL_W){1'b0}}, cap_q};
    end else begin
      prdata = {{(32-THR_W){1'b0}}, thr_q};
    end
  end

  // Effective capacity and threshold after clamping
  logic [FILL_W-1:0] cap_eff;
  logic [THR_W-1:0]  thr_eff;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = FILL_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = FILL_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
    thr_eff = (thr_q > THR_FULL) ? THR_FULL : thr_q;
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic acc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Access decode and state update
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0] in_mode;
  logic [LEN_W-1:0]  in_len;
  logic [DATA_W-1:0] in_data;

  assign in_mode = s_axis_tdata_i[1:0];
  assign in_len  = s_axis_tdata_i[5:2];
  assign in_data = s_axis_tdata_i[69:6];

  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  ovr_q, ovr_d;
  logic [CNT_W-1:0]  und_q, und_d;
  logic [TOT_W-1:0]  wtot_q, wtot_d;
  logic [TOT_W-1:0]  rtot_q, rtot_d;

  logic [LEN_W-1:0]  len_c;
  logic [LEN_W-1:0]  moved;
  logic              do_write;
  logic              do_read;

  always_comb begin
    logic [FILL_W-1:0] space;
    logic [FILL_W-1:0] fill_w;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;

    len_c = (32'(in_len) > LANES) ? LEN_W'(LANES) : in_len;
    space = cap_eff - fill_q;
    fill_w = '0;
    lhs = '0;
    rhs = PROD_W'(thr_eff) * PROD_W'(cap_eff);

    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    phase_d  = phase_q;
    ovr_d    = ovr_q;
    und_d    = und_q;
    wtot_d   = wtot_q;
    rtot_d   = rtot_q;
    moved    = '0;
    do_write = 1'b0;
    do_read  = 1'b0;

    case (in_mode)
      MODE_WRITE: begin
        if (len_c != '0) begin
          do_write = 1'b1;
          moved    = (FILL_W'(len_c) < space) ? len_c : LEN_W'(space);
          fill_w   = fill_q + FILL_W'(moved);
          fill_d   = fill_w;
          tail_d   = tail_q + AW'(moved);
          if (moved < len_c) begin
            ovr_d = ovr_q + CNT_W'(1);
          end
          if (moved != '0) begin
            wtot_d = wtot_q + TOT_W'(moved);
            if (phase_q != PH_STREAM) begin
              lhs = PROD_W'({fill_w, 16'd0});
              if (lhs >= rhs) begin
                phase_d = PH_STREAM;
              end else if (phase_q == PH_EMPTY) begin
                phase_d = PH_PREBUF;
              end
            end
          end
        end
      end
      MODE_READ: begin
        if (len_c != '0 && (phase_q == PH_STREAM || phase_q == PH_UNDER)) begin
          do_read = 1'b1;
          moved   = (FILL_W'(len_c) < fill_q) ? len_c : LEN_W'(fill_q);
          fill_d  = fill_q - FILL_W'(moved);
          head_d  = head_q + AW'(moved);
          rtot_d  = rtot_q + TOT_W'(moved);
          if (moved < len_c && phase_q == PH_STREAM) begin
            und_d = und_q + CNT_W'(1);
            if (fill_d == '0) begin
              phase_d = PH_UNDER;
            end
          end
        end
      end
      MODE_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        fill_d  = '0;
        phase_d = PH_EMPTY;
        ovr_d   = '0;
        und_d   = '0;
        wtot_d  = '0;
        rtot_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      phase_q <= PH_EMPTY;
      ovr_q   <= '0;
      und_q   <= '0;
      wtot_q  <= '0;
      rtot_q  <= '0;
    end else if (cfg_cap_wr) begin
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      phase_q <= PH_EMPTY;
      ovr_q   <= '0;
      und_q   <= '0;
      wtot_q  <= '0;
      rtot_q  <= '0;
    end else if (acc) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      ovr_q   <= ovr_d;
      und_q   <= und_d;
      wtot_q  <= wtot_d;
      rtot_q  <= rtot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Banked byte store: lane k of an access lands in bank (ptr + k) mod NB
  // ---------------------------------------------------------------------------
  logic [BIW-1:0] tail_bank, head_bank;
  logic [RW-1:0]  tail_row, head_row;

  assign tail_bank = BIW'(tail_q % NB);
  assign head_bank = BIW'(head_q % NB);
  assign tail_row  = RW'(tail_q / NB);
  assign head_row  = RW'(head_q / NB);

  logic [7:0]    wr_byte [NB];
  logic [RW-1:0] wr_row  [NB];
  logic [RW-1:0] rd_row  [NB];
  logic [NB-1:0] wr_en;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      logic [BIW-1:0] lane;
      lane       = BIW'(b) - tail_bank;
      wr_byte[b] = in_data[8*lane +: 8];
      wr_row[b]  = tail_row + RW'(BIW'(b) < tail_bank);
      rd_row[b]  = head_row + RW'(BIW'(b) < head_bank);
      wr_en[b]   = acc && do_write && (LEN_W'(lane) < moved);
    end
  end

  logic [7:0] mem  [NB][ROWS];
  logic [7:0] rd_q [NB];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NB; b++) begin
      if (wr_en[b]) begin
        mem[b][wr_row[b]] <= wr_byte[b];
      end
      if (acc) begin
        rd_q[b] <= mem[b][rd_row[b]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]  res_moved_q;
  logic [LEN_W-1:0]  res_rd_cnt_q;
  logic [BIW-1:0]    res_rot_q;
  logic [1:0]        res_phase_q;
  logic [FILL_W-1:0] res_fill_q;
  logic [CNT_W-1:0]  res_ovr_q;
  logic [CNT_W-1:0]  res_und_q;
  logic [TOT_W-1:0]  res_wtot_q;
  logic [TOT_W-1:0]  res_rtot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_moved_q  <= moved;
      res_rd_cnt_q <= do_read ? moved : '0;
      res_rot_q    <= head_bank;
      res_phase_q  <= phase_d;
      res_fill_q   <= fill_d;
      res_ovr_q    <= ovr_d;
      res_und_q    <= und_d;
      res_wtot_q   <= wtot_d;
      res_rtot_q   <= rtot_d;
    end
  end

  // Realign bank outputs to item byte order, zero the unused bytes
  logic [DATA_W-1:0] rd_bytes;

  always_comb begin
    rd_bytes = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < NB && LEN_W'(k) < res_rd_cnt_q) begin
        rd_bytes[8*k +: 8] = rd_q[BIW'(res_rot_q + BIW'(k))];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_rtot_q, res_wtot_q, res_und_q, res_ovr_q,
                            res_fill_q, res_phase_q, rd_bytes, res_moved_q};

endmodule
